/* design/vr_pkg.sv */
package vr_pkg;

    localparam int IDX_W       = 16;   // refractive index, Q2.14
    localparam int ETA_W       = 32;   // eta, unsigned Q16
    localparam int D_W         = 29;   // |d| in Q28, at most 1.0
    localparam int V_W         = 45;   // v in Q28 before the second eta product
    localparam int ED_W        = 30;   // eta * d rescaled to Q14
    localparam int K_W         = 30;   // sqrt radicand, Q28 padded to an even width
    localparam int ROOT_W      = 15;   // floor(sqrt(k)), Q14
    localparam int C_W         = 31;   // eta * d - sqrt(k), signed Q14
    localparam int PROD_W      = 77;   // exact v * eta
    localparam int OUT_W       = 20;   // result components, Q5.14

    localparam int DIV_STAGES  = 8;
    localparam int DIV_STEP    = ETA_W / DIV_STAGES;
    localparam int SQRT_STAGES = 5;
    localparam int SQRT_STEP   = (K_W / 2) / SQRT_STAGES;

    localparam logic [D_W-1:0]      ONE_Q28   = 29'h1000_0000;
    localparam logic [OUT_W-1:0]    ONE_Q14   = 20'd16384;
    localparam int                  OUT_MAX   = 524287;
    // t = v * eta / 2^16 exceeds 1.0 exactly when the product reaches this.
    localparam logic [PROD_W-1:0]   TIR_LIMIT = (77'd1 << 44) + (77'd1 << 16);

    typedef enum logic [1:0] {
        ST_REFRACT  = 2'd0,
        ST_TIR      = 2'd1,
        ST_ZERO_DIV = 2'd2
    } status_t;

endpackage

/* design/vr_div.sv */
module vr_div (
    input  logic                            aclk,
    input  logic [vr_pkg::DIV_STAGES-1:0]   en,
    input  logic [vr_pkg::IDX_W-1:0]        dividend_hi,
    input  logic [vr_pkg::IDX_W-1:0]        divisor,
    output logic [vr_pkg::ETA_W-1:0]        quotient
);

    localparam int NS   = vr_pkg::DIV_STAGES;
    localparam int STEP = vr_pkg::DIV_STEP;
    localparam int QW   = vr_pkg::ETA_W;
    localparam int RW   = vr_pkg::IDX_W;

    logic [RW-1:0] rem_reg [NS];
    logic [RW-1:0] rem_next [NS];
    logic [QW-1:0] q_reg [NS];
    logic [QW-1:0] q_next [NS];
    logic [QW-1:0] dd_reg [NS];
    logic [QW-1:0] dd_next [NS];
    logic [RW-1:0] dsr_reg [NS];
    logic [RW-1:0] dsr_next [NS];

    // Restoring division, STEP quotient bits per stage, dividend = dividend_hi << 16.
    always_comb begin
        logic [RW:0]   r;
        logic [QW-1:0] q;
        logic [QW-1:0] dd;
        logic [RW-1:0] dsr;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                r   = '0;
                q   = '0;
                dd  = {dividend_hi, {(QW-RW){1'b0}}};
                dsr = divisor;
            end else begin
                r   = {1'b0, rem_reg[s-1]};
                q   = q_reg[s-1];
                dd  = dd_reg[s-1];
                dsr = dsr_reg[s-1];
            end
            for (int j = 0; j < STEP; j++) begin
                r  = {r[RW-1:0], dd[QW-1]};
                dd = dd << 1;
                if (r >= {1'b0, dsr}) begin
                    r = r - {1'b0, dsr};
                    q = {q[QW-2:0], 1'b1};
                end else begin
                    q = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[s] = r[RW-1:0];
            q_next[s]   = q;
            dd_next[s]  = dd;
            dsr_next[s] = dsr;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                dd_reg[s]  <= dd_next[s];
                dsr_reg[s] <= dsr_next[s];
            end
        end
    end

    assign quotient = q_reg[NS-1];

endmodule

/* design/vr_sqrt.sv */
module vr_sqrt (
    input  logic                            aclk,
    input  logic [vr_pkg::SQRT_STAGES-1:0]  en,
    input  logic [vr_pkg::K_W-1:0]          radicand,
    output logic [vr_pkg::ROOT_W-1:0]       root
);

    localparam int NS   = vr_pkg::SQRT_STAGES;
    localparam int STEP = vr_pkg::SQRT_STEP;
    localparam int KW   = vr_pkg::K_W;
    localparam int SW   = vr_pkg::ROOT_W;
    localparam int RW   = vr_pkg::ROOT_W + 2;

    logic [RW-1:0] rem_reg [NS];
    logic [RW-1:0] rem_next [NS];
    logic [SW-1:0] root_reg [NS];
    logic [SW-1:0] root_next [NS];
    logic [KW-1:0] rad_reg [NS];
    logic [KW-1:0] rad_next [NS];

    // Digit-by-digit square root, one result bit per step, STEP steps per stage.
    always_comb begin
        logic [RW+1:0] r;
        logic [RW-1:0] trial;
        logic [SW-1:0] q;
        logic [KW-1:0] x;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                r = '0;
                q = '0;
                x = radicand;
            end else begin
                r = {2'b00, rem_reg[s-1]};
                q = root_reg[s-1];
                x = rad_reg[s-1];
            end
            for (int j = 0; j < STEP; j++) begin
                r     = {r[RW-1:0], x[KW-1:KW-2]};
                x     = x << 2;
                trial = {q, 2'b01};
                if (r >= {2'b00, trial}) begin
                    r = r - {2'b00, trial};
                    q = {q[SW-2:0], 1'b1};
                end else begin
                    q = {q[SW-2:0], 1'b0};
                end
            end
            rem_next[s]  = r[RW-1:0];
            root_next[s] = q;
            rad_next[s]  = x;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

/* design/vector_refraction.sv */
// Refracts a ray direction at a surface by Snell's law in fixed point.
// Input channel (s_valid / s_ready): direction and normal components in
// signed Q1.14 at COMP_WIDTH bits, and the two refractive indices in
// unsigned Q2.14. Result channel (m_valid / m_ready): the refracted
// direction in signed Q5.14, saturated, and a status code (refracted,
// total internal reflection, or zero divisor index).
// Every input item gives exactly one result item, in order.
// From acceptance to m_valid an item passes three stages for the dot
// product, clamp and flip, eight for the eta divider (four quotient bits
// each), three for the eta products and the reflection test, five for the
// square root (three root bits each) and two for the final products and
// saturation. A new item can be accepted every cycle while s_ready is high.
// Each stage advances whenever its successor is empty or advancing, so a
// stall on m_ready fills empty stages first and only then drops s_ready.
// A result waiting in the output register holds its value until taken.
// Reset (aresetn low at a clock edge) empties the pipeline and discards any
// item in flight.
module vector_refraction #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMP_WIDTH-1:0] s_dir_x,
    input  logic signed [COMP_WIDTH-1:0] s_dir_y,
    input  logic signed [COMP_WIDTH-1:0] s_dir_z,
    input  logic signed [COMP_WIDTH-1:0] s_norm_x,
    input  logic signed [COMP_WIDTH-1:0] s_norm_y,
    input  logic signed [COMP_WIDTH-1:0] s_norm_z,
    input  logic [15:0]                 s_index_from,
    input  logic [15:0]                 s_index_to,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [19:0]          m_out_x,
    output logic signed [19:0]          m_out_y,
    output logic signed [19:0]          m_out_z,
    output logic [1:0]                  m_status
);

    localparam int W     = COMP_WIDTH;
    localparam int NW    = COMP_WIDTH + 1;
    localparam int PW    = 2 * COMP_WIDTH;
    localparam int SUM_W = 2 * COMP_WIDTH + 2;
    localparam int CMP_W = (SUM_W > 30) ? SUM_W : 30;
    localparam int DW    = vr_pkg::D_W;
    localparam int EW    = vr_pkg::ETA_W;
    localparam int IW    = vr_pkg::IDX_W;
    localparam int A_PW  = COMP_WIDTH + vr_pkg::ETA_W + 1;
    localparam int A_W   = A_PW - 16;
    localparam int B_PW  = COMP_WIDTH + 1 + vr_pkg::C_W;
    localparam int B_W   = B_PW - 14;
    localparam int S_W   = ((A_W > B_W) ? A_W : B_W) + 1;
    localparam int OW    = vr_pkg::OUT_W;

    localparam int DIV0 = 3;
    localparam int E1   = DIV0 + vr_pkg::DIV_STAGES;
    localparam int E2   = E1 + 1;
    localparam int E3   = E2 + 1;
    localparam int SQ0  = E3 + 1;
    localparam int F1   = SQ0 + vr_pkg::SQRT_STAGES;
    localparam int F2   = F1 + 1;
    localparam int NST  = F2 + 1;

    localparam logic signed [CMP_W-1:0] LIM_P = CMP_W'(vr_pkg::ONE_Q28);
    localparam logic signed [CMP_W-1:0] LIM_N = -LIM_P;
    localparam logic [2*DW-1:0]         ONE_Q56 = 58'h100000000000000;
    localparam logic signed [S_W-1:0]   SAT_HI = S_W'(vr_pkg::OUT_MAX);
    localparam logic signed [S_W-1:0]   SAT_LO = -SAT_HI - S_W'(1);

    typedef struct packed {
        logic [2:0][W-1:0]  dv;
        logic [2:0][NW-1:0] nv;
        logic [DW-1:0]      d;
        logic [DW-1:0]      u;
        logic               zdiv;
    } div_side_t;

    typedef struct packed {
        logic [2:0][A_W-1:0]        a;
        logic [2:0][NW-1:0]         nv;
        logic [vr_pkg::ED_W-1:0]    ed;
        logic                       zdiv;
        logic                       tir;
    } sq_side_t;

    // ---------------------------------------------------------------- control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;
    logic [NST-1:0] vld_in;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign vld_in = {vld_reg[NST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];

    // ------------------------------------------------- stage 0: dot products
    logic signed [W-1:0]  dv_in [3];
    logic signed [W-1:0]  nv_in [3];
    logic signed [PW-1:0] prod0_reg [3];
    logic signed [W-1:0]  dv0_reg [3];
    logic signed [W-1:0]  nv0_reg [3];
    logic [IW-1:0]        n1_0_reg, n2_0_reg;

    assign dv_in[0] = s_dir_x;
    assign dv_in[1] = s_dir_y;
    assign dv_in[2] = s_dir_z;
    assign nv_in[0] = s_norm_x;
    assign nv_in[1] = s_norm_y;
    assign nv_in[2] = s_norm_z;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                prod0_reg[i] <= dv_in[i] * nv_in[i];
                dv0_reg[i]   <= dv_in[i];
                nv0_reg[i]   <= nv_in[i];
            end
            n1_0_reg <= s_index_from;
            n2_0_reg <= s_index_to;
        end
    end

    // -------------------------------------------------------- stage 1: sum
    logic signed [SUM_W-1:0] sum1_reg;
    logic signed [W-1:0]     dv1_reg [3];
    logic signed [W-1:0]     nv1_reg [3];
    logic [IW-1:0]           n1_1_reg, n2_1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sum1_reg <= SUM_W'(prod0_reg[0]) + SUM_W'(prod0_reg[1]) + SUM_W'(prod0_reg[2]);
            dv1_reg  <= dv0_reg;
            nv1_reg  <= nv0_reg;
            n1_1_reg <= n1_0_reg;
            n2_1_reg <= n2_0_reg;
        end
    end

    // ------------------------------------------------ stage 2: clamp, flip
    logic signed [CMP_W-1:0] sum_x;
    logic                    neg;
    logic [DW-1:0]           d_next;
    logic signed [NW-1:0]    nvf_next [3];

    logic [DW-1:0]           d2_reg;
    logic signed [W-1:0]     dv2_reg [3];
    logic signed [NW-1:0]    nv2_reg [3];
    logic [IW-1:0]           n1f_reg, n2f_reg;

    always_comb begin
        sum_x = CMP_W'(sum1_reg);
        neg   = sum_x < 0;
        if (neg) begin
            d_next = (sum_x < LIM_N) ? vr_pkg::ONE_Q28 : DW'(-sum_x);
        end else begin
            d_next = (sum_x > LIM_P) ? vr_pkg::ONE_Q28 : DW'(sum_x);
        end
        for (int i = 0; i < 3; i++) begin
            nvf_next[i] = neg ? -NW'(nv1_reg[i]) : NW'(nv1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d2_reg  <= d_next;
            dv2_reg <= dv1_reg;
            nv2_reg <= nvf_next;
            n1f_reg <= neg ? n2_1_reg : n1_1_reg;
            n2f_reg <= neg ? n1_1_reg : n2_1_reg;
        end
    end

    // ------------------------------------------------ divider, eta = n2 / n1
    logic [2*DW-1:0] dsq;
    logic [2*DW-1:0] udiff;
    div_side_t       div_entry;
    div_side_t       div_side_reg [vr_pkg::DIV_STAGES];
    logic [EW-1:0]   eta;

    always_comb begin
        dsq   = d2_reg * d2_reg;
        udiff = ONE_Q56 - dsq;
        for (int i = 0; i < 3; i++) begin
            div_entry.dv[i] = dv2_reg[i];
            div_entry.nv[i] = nv2_reg[i];
        end
        div_entry.d    = d2_reg;
        div_entry.u    = udiff[56:28];
        div_entry.zdiv = (n1f_reg == '0);
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < vr_pkg::DIV_STAGES; s++) begin
            if (en[DIV0 + s]) begin
                div_side_reg[s] <= (s == 0) ? div_entry : div_side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    vr_div u_div (
        .aclk        (aclk),
        .en          (en[DIV0 +: vr_pkg::DIV_STAGES]),
        .dividend_hi (n2f_reg),
        .divisor     (n1f_reg),
        .quotient    (eta)
    );

    // ------------------------------------------- E1: products with eta
    div_side_t                    ds;
    logic signed [A_PW-1:0]       a_prod [3];
    logic [EW+DW-1:0]             v_prod;
    logic [EW+DW-1:0]             ed_prod;

    logic [2:0][A_W-1:0]          a1_reg;
    logic [vr_pkg::V_W-1:0]       v1_reg;
    logic [vr_pkg::ED_W-1:0]      ed1_reg;
    logic [EW-1:0]                eta1_reg;
    logic [2:0][NW-1:0]           nv_e1_reg;
    logic                         zdiv1_reg;

    always_comb begin
        ds = div_side_reg[vr_pkg::DIV_STAGES-1];
        for (int i = 0; i < 3; i++) begin
            a_prod[i] = $signed(ds.dv[i]) * $signed({1'b0, eta});
        end
        v_prod  = eta * ds.u;
        ed_prod = eta * ds.d;
    end

    always_ff @(posedge aclk) begin
        if (en[E1]) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= a_prod[i][A_PW-1:16];
            end
            v1_reg    <= v_prod[EW+DW-1:16];
            ed1_reg   <= ed_prod[59:30];
            eta1_reg  <= eta;
            nv_e1_reg <= ds.nv;
            zdiv1_reg <= ds.zdiv;
        end
    end

    // ------------------------------------------- E2: v * eta in two halves
    logic [EW+DW-1:0]             phi2_reg;
    logic [EW+15:0]               plo2_reg;
    logic [2:0][A_W-1:0]          a2_reg;
    logic [vr_pkg::ED_W-1:0]      ed2_reg;
    logic [2:0][NW-1:0]           nv_e2_reg;
    logic                         zdiv2_reg;

    always_ff @(posedge aclk) begin
        if (en[E2]) begin
            phi2_reg  <= v1_reg[vr_pkg::V_W-1:16] * eta1_reg;
            plo2_reg  <= v1_reg[15:0] * eta1_reg;
            a2_reg    <= a1_reg;
            ed2_reg   <= ed1_reg;
            nv_e2_reg <= nv_e1_reg;
            zdiv2_reg <= zdiv1_reg;
        end
    end

    // ---------------------------------- E3: reflection test and radicand k
    logic [vr_pkg::PROD_W-1:0]    vprod;
    logic                         tir_next;
    logic [vr_pkg::K_W-1:0]       k_next;
    logic [vr_pkg::K_W-1:0]       k3_reg;
    sq_side_t                     sq_entry_reg;

    always_comb begin
        vprod    = {phi2_reg, 16'b0} + vr_pkg::PROD_W'(plo2_reg);
        tir_next = vprod >= vr_pkg::TIR_LIMIT;
        k_next   = vr_pkg::K_W'(vr_pkg::ONE_Q28) - vr_pkg::K_W'(vprod[44:16]);
    end

    always_ff @(posedge aclk) begin
        if (en[E3]) begin
            k3_reg            <= k_next;
            sq_entry_reg.a    <= a2_reg;
            sq_entry_reg.nv   <= nv_e2_reg;
            sq_entry_reg.ed   <= ed2_reg;
            sq_entry_reg.zdiv <= zdiv2_reg;
            sq_entry_reg.tir  <= tir_next;
        end
    end

    // ---------------------------------------------------- square root of k
    sq_side_t                   sq_side_reg [vr_pkg::SQRT_STAGES];
    logic [vr_pkg::ROOT_W-1:0]  root;

    always_ff @(posedge aclk) begin
        for (int s = 0; s < vr_pkg::SQRT_STAGES; s++) begin
            if (en[SQ0 + s]) begin
                sq_side_reg[s] <= (s == 0) ? sq_entry_reg : sq_side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    vr_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en[SQ0 +: vr_pkg::SQRT_STAGES]),
        .radicand (k3_reg),
        .root     (root)
    );

    // ------------------------------------------ F1: normal scale products
    sq_side_t                   qs;
    logic signed [vr_pkg::C_W-1:0] c;
    logic signed [B_PW-1:0]     b_prod [3];

    logic signed [A_W-1:0]      a_f1_reg [3];
    logic signed [B_W-1:0]      b_f1_reg [3];
    logic                       zdiv_f1_reg;
    logic                       tir_f1_reg;

    always_comb begin
        qs = sq_side_reg[vr_pkg::SQRT_STAGES-1];
        c  = $signed(vr_pkg::C_W'(qs.ed)) - $signed(vr_pkg::C_W'(root));
        for (int i = 0; i < 3; i++) begin
            b_prod[i] = $signed(qs.nv[i]) * c;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[F1]) begin
            for (int i = 0; i < 3; i++) begin
                a_f1_reg[i] <= $signed(qs.a[i]);
                b_f1_reg[i] <= b_prod[i][B_PW-1:14];
            end
            zdiv_f1_reg <= qs.zdiv;
            tir_f1_reg  <= qs.tir;
        end
    end

    // ----------------------------------------- F2: sum, saturate, select
    logic signed [S_W-1:0]  osum [3];
    logic signed [OW-1:0]   out_next [3];
    vr_pkg::status_t        status_next;

    logic signed [OW-1:0]   out_reg [3];
    vr_pkg::status_t        status_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            osum[i] = S_W'(a_f1_reg[i]) + S_W'(b_f1_reg[i]);
            if (osum[i] > SAT_HI) begin
                out_next[i] = OW'(SAT_HI);
            end else if (osum[i] < SAT_LO) begin
                out_next[i] = OW'(SAT_LO);
            end else begin
                out_next[i] = OW'(osum[i]);
            end
        end
        status_next = vr_pkg::ST_REFRACT;
        priority if (zdiv_f1_reg) begin
            out_next[0] = '0;
            out_next[1] = '0;
            out_next[2] = '0;
            status_next = vr_pkg::ST_ZERO_DIV;
        end else if (tir_f1_reg) begin
            out_next[0] = vr_pkg::ONE_Q14;
            out_next[1] = '0;
            out_next[2] = '0;
            status_next = vr_pkg::ST_TIR;
        end else begin
            status_next = vr_pkg::ST_REFRACT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[F2]) begin
            out_reg    <= out_next;
            status_reg <= status_next;
        end
    end

    assign m_out_x  = out_reg[0];
    assign m_out_y  = out_reg[1];
    assign m_out_z  = out_reg[2];
    assign m_status = status_reg;

    // -------------------------------------------------------- assertions
    a_tir_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == vr_pkg::ST_TIR) |->
            (m_out_x == vr_pkg::ONE_Q14 && m_out_y == '0 && m_out_z == '0))
        else $error("total internal reflection item carries a wrong vector");

    a_zdiv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == vr_pkg::ST_ZERO_DIV) |->
            (m_out_x == '0 && m_out_y == '0 && m_out_z == '0))
        else $error("zero divisor item carries a nonzero vector");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && vld_reg == '1))
        else $error("input stalled while the pipeline had room");

endmodule
